/* rtl/core/quaternion_to_rotation_matrix_unit_assert.svh */
// Assertion macros for the quaternion to rotation matrix unit.
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QRM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QRM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/qrm_pkg.sv */
`default_nettype none
package qrm_pkg;

  localparam int unsigned NUM_ENT     = 9;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam int unsigned ENT_M00 = 0;
  localparam int unsigned ENT_M01 = 1;
  localparam int unsigned ENT_M02 = 2;
  localparam int unsigned ENT_M10 = 3;
  localparam int unsigned ENT_M11 = 4;
  localparam int unsigned ENT_M12 = 5;
  localparam int unsigned ENT_M20 = 6;
  localparam int unsigned ENT_M21 = 7;
  localparam int unsigned ENT_M22 = 8;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

endpackage
`default_nettype wire

/* rtl/core/qrm_intf.sv */
`default_nettype none
interface quat_in_if #(parameter int IN_WIDTH = 16);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] quat_w;
  logic signed [IN_WIDTH-1:0] quat_x;
  logic signed [IN_WIDTH-1:0] quat_y;
  logic signed [IN_WIDTH-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface mat_out_if #(parameter int OUT_FRAC_BITS = 14);
  localparam int OW = OUT_FRAC_BITS + 2;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] m00;
  logic signed [OW-1:0] m01;
  logic signed [OW-1:0] m02;
  logic signed [OW-1:0] m10;
  logic signed [OW-1:0] m11;
  logic signed [OW-1:0] m12;
  logic signed [OW-1:0] m20;
  logic signed [OW-1:0] m21;
  logic signed [OW-1:0] m22;
  logic                 zero_norm_error;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_norm_error, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_norm_error, output ready);
endinterface
`default_nettype wire

/* rtl/core/qrm_front.sv */
`default_nettype none
module qrm_front #(
  parameter int IN_WIDTH = 16,
  parameter int ENT_W    = 1 + 2*IN_WIDTH + 9*(2*IN_WIDTH+2)
) (
  input  logic             clk,
  input  logic             rst_n,
  quat_in_if.sink          in_chan,
  input  qrm_pkg::q_stat_t q_stat,
  output logic             push,
  output logic [ENT_W-1:0] push_data
);
  import qrm_pkg::*;

  localparam int PW = 2*IN_WIDTH;
  localparam int SW = 2*IN_WIDTH;
  localparam int DW = 2*IN_WIDTH + 2;

  logic v1_r, v2_r;
  logic [QCNT_W:0] pend;
  logic all_min;
  logic signed [IN_WIDTH-1:0] wv, xv, yv, zv;
  logic signed [PW-1:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt;
  logic signed [PW-1:0] xy_nxt, zw_nxt, xz_nxt, yw_nxt, yz_nxt, xw_nxt;
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  logic signed [DW-1:0] eww, exx, eyy, ezz, exy, ezw, exz, eyw, eyz, exw, s_full;
  logic signed [DW-1:0] d_nxt [NUM_ENT];
  logic signed [DW-1:0] d_r   [NUM_ENT];
  logic [SW-1:0] s_nxt, s_r;
  logic zero_r;

  assign pend = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(v1_r) + (QCNT_W+1)'(v2_r);
  assign in_chan.ready = pend < (QCNT_W+1)'(QUEUE_DEPTH);

  localparam logic [IN_WIDTH-1:0] MINV = {1'b1, {(IN_WIDTH-1){1'b0}}};

  always_comb begin
    all_min = (in_chan.quat_w == MINV) && (in_chan.quat_x == MINV) &&
              (in_chan.quat_y == MINV) && (in_chan.quat_z == MINV);
    wv = all_min ? (in_chan.quat_w >>> 1) : in_chan.quat_w;
    xv = all_min ? (in_chan.quat_x >>> 1) : in_chan.quat_x;
    yv = all_min ? (in_chan.quat_y >>> 1) : in_chan.quat_y;
    zv = all_min ? (in_chan.quat_z >>> 1) : in_chan.quat_z;
    ww_nxt = wv * wv;
    xx_nxt = xv * xv;
    yy_nxt = yv * yv;
    zz_nxt = zv * zv;
    xy_nxt = xv * yv;
    zw_nxt = zv * wv;
    xz_nxt = xv * zv;
    yw_nxt = yv * wv;
    yz_nxt = yv * zv;
    xw_nxt = xv * wv;
  end

  always_ff @(posedge clk) begin
    ww_r <= ww_nxt; xx_r <= xx_nxt; yy_r <= yy_nxt; zz_r <= zz_nxt;
    xy_r <= xy_nxt; zw_r <= zw_nxt; xz_r <= xz_nxt; yw_r <= yw_nxt;
    yz_r <= yz_nxt; xw_r <= xw_nxt;
  end

  always_comb begin
    eww = $signed({{2{ww_r[PW-1]}}, ww_r});
    exx = $signed({{2{xx_r[PW-1]}}, xx_r});
    eyy = $signed({{2{yy_r[PW-1]}}, yy_r});
    ezz = $signed({{2{zz_r[PW-1]}}, zz_r});
    exy = $signed({{2{xy_r[PW-1]}}, xy_r});
    ezw = $signed({{2{zw_r[PW-1]}}, zw_r});
    exz = $signed({{2{xz_r[PW-1]}}, xz_r});
    eyw = $signed({{2{yw_r[PW-1]}}, yw_r});
    eyz = $signed({{2{yz_r[PW-1]}}, yz_r});
    exw = $signed({{2{xw_r[PW-1]}}, xw_r});
    s_full = eww + exx + eyy + ezz;
    s_nxt  = s_full[SW-1:0];
    d_nxt[ENT_M00] = (eww + exx) - (eyy + ezz);
    d_nxt[ENT_M11] = (eww + eyy) - (exx + ezz);
    d_nxt[ENT_M22] = (eww + ezz) - (exx + eyy);
    d_nxt[ENT_M01] = (exy - ezw) <<< 1;
    d_nxt[ENT_M10] = (exy + ezw) <<< 1;
    d_nxt[ENT_M02] = (exz + eyw) <<< 1;
    d_nxt[ENT_M20] = (exz - eyw) <<< 1;
    d_nxt[ENT_M12] = (eyz - exw) <<< 1;
    d_nxt[ENT_M21] = (eyz + exw) <<< 1;
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    zero_r <= (s_nxt == '0);
    d_r    <= d_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_chan.valid && in_chan.ready;
      v2_r <= v1_r;
    end
  end

  assign push = v2_r;

  always_comb begin
    push_data[ENT_W-1]        = zero_r;
    push_data[ENT_W-2 -: SW]  = s_r;
    for (int k = 0; k < NUM_ENT; k++) begin
      push_data[k*DW +: DW] = d_r[k];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/qrm_queue.sv */
`default_nettype none
module qrm_queue #(
  parameter int ENT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [ENT_W-1:0] push_data,
  input  logic             pop,
  output logic [ENT_W-1:0] head_data,
  output qrm_pkg::q_stat_t stat
);
  import qrm_pkg::*;

  logic [ENT_W-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
endmodule
`default_nettype wire

/* rtl/core/qrm_back.sv */
`default_nettype none
module qrm_back #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14,
  parameter int ENT_W         = 1 + 2*IN_WIDTH + 9*(2*IN_WIDTH+2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qrm_pkg::q_stat_t q_stat,
  input  logic [ENT_W-1:0] head_data,
  output logic             pop,
  mat_out_if.source        out_chan
);
  import qrm_pkg::*;

  localparam int SW = 2*IN_WIDTH;
  localparam int DW = 2*IN_WIDTH + 2;
  localparam int RW = 2*IN_WIDTH + 1;
  localparam int QW = OUT_FRAC_BITS + 2;
  localparam int F  = OUT_FRAC_BITS;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;

  logic en;
  logic out_valid_r;
  logic [F:0]    v_r;
  logic [SW-1:0] s_r    [F+1];
  logic          zero_r [F+1];
  logic [RW-1:0] r_r    [F+1][NUM_ENT];
  logic [QW-1:0] q_r    [F+1][NUM_ENT];
  logic          neg_r  [F+1][NUM_ENT];
  logic signed [QW-1:0] m_r [NUM_ENT];
  logic zerr_r;

  assign en  = !out_valid_r || out_chan.ready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[F-1:0], !q_stat.empty};
      out_valid_r <= v_r[F];
    end
  end

  // setup: magnitude, sign, integer quotient bit
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] d;
    logic [DW-1:0] mag;
    logic [DW-1:0] s_ext;
    if (en) begin
      s_r[0]    <= head_data[ENT_W-2 -: SW];
      zero_r[0] <= head_data[ENT_W-1];
      s_ext = DW'(head_data[ENT_W-2 -: SW]);
      for (int k = 0; k < NUM_ENT; k++) begin
        d   = $signed(head_data[k*DW +: DW]);
        mag = d[DW-1] ? DW'(-d) : DW'(d);
        neg_r[0][k] <= d[DW-1];
        if (mag >= s_ext) begin
          q_r[0][k] <= QW'(1);
          r_r[0][k] <= '0;
        end else begin
          q_r[0][k] <= '0;
          r_r[0][k] <= mag[RW-1:0];
        end
      end
    end
  end

  for (genvar g = 1; g <= F; g++) begin : g_step
    always_ff @(posedge clk) begin
      logic [RW:0] t;
      if (en) begin
        s_r[g]    <= s_r[g-1];
        zero_r[g] <= zero_r[g-1];
        for (int k = 0; k < NUM_ENT; k++) begin
          t = {r_r[g-1][k], 1'b0};
          neg_r[g][k] <= neg_r[g-1][k];
          if (t >= (RW+1)'(s_r[g-1])) begin
            r_r[g][k] <= RW'(t - (RW+1)'(s_r[g-1]));
            q_r[g][k] <= {q_r[g-1][k][QW-2:0], 1'b1};
          end else begin
            r_r[g][k] <= t[RW-1:0];
            q_r[g][k] <= {q_r[g-1][k][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round half up, clamp, apply sign
  always_ff @(posedge clk) begin
    logic [RW:0]   t;
    logic [QW-1:0] q;
    if (en) begin
      zerr_r <= zero_r[F];
      for (int k = 0; k < NUM_ENT; k++) begin
        t = {r_r[F][k], 1'b0};
        q = q_r[F][k];
        if (t >= (RW+1)'(s_r[F])) q = q + 1'b1;
        if (q > ONE_Q) q = ONE_Q;
        if (neg_r[F][k]) q = -q;
        m_r[k] <= zero_r[F] ? '0 : $signed(q);
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.m00             = m_r[ENT_M00];
  assign out_chan.m01             = m_r[ENT_M01];
  assign out_chan.m02             = m_r[ENT_M02];
  assign out_chan.m10             = m_r[ENT_M10];
  assign out_chan.m11             = m_r[ENT_M11];
  assign out_chan.m12             = m_r[ENT_M12];
  assign out_chan.m20             = m_r[ENT_M20];
  assign out_chan.m21             = m_r[ENT_M21];
  assign out_chan.m22             = m_r[ENT_M22];
  assign out_chan.zero_norm_error = zerr_r;
endmodule
`default_nettype wire

/* rtl/core/quaternion_to_rotation_matrix_unit.sv */
`default_nettype none
// Channel    Dir  Fields
// in_chan    in   quat_w, quat_x, quat_y, quat_z (signed, IN_WIDTH bits)
// out_chan   out  m00..m22 (signed, OUT_FRAC_BITS+2 bits), zero_norm_error
//
// One quaternion per cycle sustained while out_chan is not stalled.
// The restoring divider chain produces one quotient bit per stage.
// Front products and sums run two stages into a four-entry queue.
// A stall on out_chan freezes the divider chain; the front keeps filling the queue.
// Reset is synchronous, active low, and empties every stage and the queue.
module quaternion_to_rotation_matrix_unit #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  quat_in_if.sink   in_chan,
  mat_out_if.source out_chan
);
  import qrm_pkg::*;

  localparam int ENT_W = 1 + 2*IN_WIDTH + NUM_ENT*(2*IN_WIDTH+2);

  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  logic [ENT_W-1:0] q_in;
  logic [ENT_W-1:0] q_head;
  logic             mat_zero;

  qrm_front #(.IN_WIDTH(IN_WIDTH), .ENT_W(ENT_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_in)
  );

  qrm_queue #(.ENT_W(ENT_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  qrm_back #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS), .ENT_W(ENT_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (q_head),
    .pop       (q_pop),
    .out_chan  (out_chan)
  );

  assign mat_zero = (out_chan.m00 == '0) && (out_chan.m01 == '0) && (out_chan.m02 == '0) &&
                    (out_chan.m10 == '0) && (out_chan.m11 == '0) && (out_chan.m12 == '0) &&
                    (out_chan.m20 == '0) && (out_chan.m21 == '0) && (out_chan.m22 == '0);

`include "quaternion_to_rotation_matrix_unit_assert.svh"

  `QRM_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, q_push && !q_pop, !q_stat.full, "queue overflow")
  `QRM_ASSERT_NXT(a_full_holds, clk, rst_n, q_stat.full && !q_pop, q_stat.full, "full queue lost entry")
  `QRM_ASSERT_IMP(a_zero_matrix, clk, rst_n, out_chan.valid && out_chan.zero_norm_error, mat_zero, "zero norm with nonzero matrix")

endmodule
`default_nettype wire

/* bench/quaternion_to_rotation_matrix_unit_tb.sv */
module quaternion_to_rotation_matrix_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = 16;
  localparam int FB = 14;
  localparam int OW = FB + 2;
  localparam int LATENCY = FB + 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1530;

  typedef struct packed {
    logic signed [IW-1:0] w;
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic [qrm_pkg::NUM_ENT-1:0][OW-1:0] m;
    logic                                err;
  } rot_mat_t;

  logic clk;
  logic rst_n;

  quat_in_if #(.IN_WIDTH(IW)) in_chan ();
  mat_out_if #(.OUT_FRAC_BITS(FB)) out_chan ();

  quaternion_to_rotation_matrix_unit #(
    .IN_WIDTH(IW),
    .OUT_FRAC_BITS(FB)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  quat_t    pending_quats[$];
  rot_mat_t expected_mats[$];
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_off_cycles;
  int       n_errors;
  int       n_checked;
  int       n_zero_seen;
  int       quiet_cycles;
  bit       sender_paused;

  function automatic logic [OW-1:0] round_quotient(bit neg, longint unsigned mag,
                                                   longint unsigned s);
    longint unsigned q;
    longint unsigned rem;
    logic [OW-1:0]   res;
    if (mag > s) mag = s;
    q = (mag >= s) ? 1 : 0;
    rem = mag - (q != 0 ? s : 0);
    for (int i = 0; i < FB; i++) begin
      if (rem >= s - rem) begin
        rem = rem - (s - rem);
        q = (q << 1) | 1;
      end else begin
        rem = rem << 1;
        q = q << 1;
      end
    end
    if (rem >= s - rem) q++;
    if (q > (64'd1 << FB)) q = 64'd1 << FB;
    res = q[OW-1:0];
    return neg ? -res : res;
  endfunction

  function automatic logic [OW-1:0] diag_value(longint unsigned a, longint unsigned b,
                                               longint unsigned s);
    return (a >= b) ? round_quotient(0, a - b, s) : round_quotient(1, b - a, s);
  endfunction

  function automatic logic [OW-1:0] cross_value(longint p1, longint p2, bit add,
                                                longint unsigned s);
    longint d;
    d = add ? p1 + p2 : p1 - p2;
    return (d < 0) ? round_quotient(1, longint'(-d) << 1, s)
                   : round_quotient(0, d << 1, s);
  endfunction

  function automatic rot_mat_t quat_to_matrix(quat_t q);
    longint          w, x, y, z;
    longint unsigned ww, xx, yy, zz, s;
    rot_mat_t        r;
    w = q.w; x = q.x; y = q.y; z = q.z;
    if (q.w == {1'b1, {(IW-1){1'b0}}} && q.x == q.w && q.y == q.w && q.z == q.w) begin
      w = w / 2; x = x / 2; y = y / 2; z = z / 2;
    end
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    s = ww + xx + yy + zz;
    r = '0;
    if (s == 0) begin
      r.err = 1'b1;
      return r;
    end
    r.m[qrm_pkg::ENT_M00] = diag_value(ww + xx, yy + zz, s);
    r.m[qrm_pkg::ENT_M01] = cross_value(x * y, z * w, 0, s);
    r.m[qrm_pkg::ENT_M02] = cross_value(x * z, y * w, 1, s);
    r.m[qrm_pkg::ENT_M10] = cross_value(x * y, z * w, 1, s);
    r.m[qrm_pkg::ENT_M11] = diag_value(ww + yy, xx + zz, s);
    r.m[qrm_pkg::ENT_M12] = cross_value(y * z, x * w, 0, s);
    r.m[qrm_pkg::ENT_M20] = cross_value(x * z, y * w, 0, s);
    r.m[qrm_pkg::ENT_M21] = cross_value(y * z, x * w, 1, s);
    r.m[qrm_pkg::ENT_M22] = diag_value(ww + zz, xx + yy, s);
    return r;
  endfunction

  function automatic logic signed [IW-1:0] rand_component(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32) - 16;
      2: return $urandom_range(0, 1) ? 16'sh7fff - $urandom_range(0, 3)
                                     : 16'sh8000 + $urandom_range(0, 3);
      default: return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
                      + $urandom_range(0, 64) - 32;
    endcase
  endfunction

  task automatic add_quat(logic signed [IW-1:0] w, x, y, z);
    quat_t q;
    q.w = w; q.x = x; q.y = y; q.z = z;
    pending_quats.push_back(q);
  endtask

  task automatic add_random(int n);
    int mode;
    int zero_mask;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : mode - 6;
      zero_mask = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
      add_quat(zero_mask[0] ? '0 : rand_component(mode),
               zero_mask[1] ? '0 : rand_component(mode),
               zero_mask[2] ? '0 : rand_component(mode),
               zero_mask[3] ? '0 : rand_component(mode));
    end
  endtask

  task automatic wait_drained();
    while (pending_quats.size() != 0 || expected_mats.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_quats.size() != 0 && !sender_paused &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        {in_chan.quat_w, in_chan.quat_x, in_chan.quat_y, in_chan.quat_z}
          <= pending_quats.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      expected_mats.push_back(quat_to_matrix({in_chan.quat_w, in_chan.quat_x,
                                              in_chan.quat_y, in_chan.quat_z}));
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rot_mat_t got;
    rot_mat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.m[qrm_pkg::ENT_M00] = out_chan.m00;
      got.m[qrm_pkg::ENT_M01] = out_chan.m01;
      got.m[qrm_pkg::ENT_M02] = out_chan.m02;
      got.m[qrm_pkg::ENT_M10] = out_chan.m10;
      got.m[qrm_pkg::ENT_M11] = out_chan.m11;
      got.m[qrm_pkg::ENT_M12] = out_chan.m12;
      got.m[qrm_pkg::ENT_M20] = out_chan.m20;
      got.m[qrm_pkg::ENT_M21] = out_chan.m21;
      got.m[qrm_pkg::ENT_M22] = out_chan.m22;
      got.err = out_chan.zero_norm_error;
      if (expected_mats.size() == 0) begin
        $display("%0t: unexpected matrix transaction, got %h", $time, got);
        n_errors++;
      end else begin
        want = expected_mats.pop_front();
        n_checked++;
        if (want.err) n_zero_seen++;
        for (int k = 0; k < qrm_pkg::NUM_ENT; k++)
          if (got.m[k] !== want.m[k]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                     $signed(want.m[k]), $signed(got.m[k]));
            n_errors++;
          end
        if (got.err !== want.err) begin
          $display("%0t: zero_norm_error expected %b actual %b", $time,
                   want.err, got.err);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_mats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    localparam logic signed [IW-1:0] MAXV = 16'sh7fff;
    localparam logic signed [IW-1:0] MINV = 16'sh8000;
    localparam logic signed [IW-1:0] ONE = 16'sd16384;
    in_chan.valid = 1'b0;
    in_chan.quat_w = '0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    out_chan.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    sender_paused = 0;
    n_errors = 0;
    n_checked = 0;
    n_zero_seen = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_quat(0, 0, 0, 0);
    add_quat(ONE, 0, 0, 0);
    add_quat(0, ONE, 0, 0);
    add_quat(0, 0, ONE, 0);
    add_quat(0, 0, 0, ONE);
    add_quat(MINV, MINV, MINV, MINV);
    add_quat(MAXV, MAXV, MAXV, MAXV);
    add_quat(MINV, MAXV, MINV, MAXV);
    add_quat(MAXV, 0, 0, 0);
    add_quat(MINV, 0, 0, 0);
    add_quat(0, MINV, 0, 0);
    add_quat(0, 0, MAXV, 0);
    add_quat(0, 0, 0, MINV);
    add_quat(1, 0, 0, 0);
    add_quat(0, -1, 0, 0);
    add_quat(1, 1, 1, 1);
    add_quat(1, -1, 1, -1);
    add_quat(3, 0, 0, 0);
    add_quat(1, 1, 0, 0);
    add_quat(ONE, ONE, 0, 0);
    add_quat(MAXV, MINV, 0, 1);
    add_quat(11585, 0, 11585, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 55 : 33) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 55 : 33) : 0;
      add_random(N_RANDOM / 4);
      if (phase == 0) begin
        @(posedge clk);
        hold_off_cycles <= 200;
      end
      wait_drained();
      if (phase == 1) begin
        sender_paused = 1;
        repeat (LATENCY * 3) @(posedge clk);
        sender_paused = 0;
      end
    end

    wait_drained();
    repeat (LATENCY * 2) @(posedge clk);
    $display("Checked %0d rotation matrices (%0d zero-norm) under idle and stall mixes.",
             n_checked, n_zero_seen);
    if (n_errors == 0 && expected_mats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* quaternion_to_rotation_matrix_unit.f */
+incdir+rtl/core
rtl/core/qrm_pkg.sv
rtl/core/qrm_intf.sv
rtl/core/qrm_front.sv
rtl/core/qrm_queue.sv
rtl/core/qrm_back.sv
rtl/core/quaternion_to_rotation_matrix_unit.sv
bench/quaternion_to_rotation_matrix_unit_tb.sv
